>>> hdl/assert_macros.svh
// Assertion macros shared by the trigger qualifier RTL.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every rising clock edge outside reset.
`define MTQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be true at a rising clock edge outside reset.
`define MTQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MTQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define MTQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

>>> hdl/mtq_pkg.sv
// Types, codes and helper functions of the MIDI trigger qualifier.
// Used by mtq_cfg_regs, mtq_eval and the top level; depends on nothing.
package mtq_pkg;

  // Table geometry and timing constants.
  localparam int SOURCE_SLOTS = 4;
  localparam int CHANNELS = 16;
  localparam int ENTRIES = SOURCE_SLOTS * CHANNELS;
  localparam int ENTRY_AW = $clog2(ENTRIES);
  localparam int TIME_BITS = 32;
  localparam logic [15:0] SETTLE_MS = 16'd200;
  localparam int APB_AW = 5;

  typedef logic [TIME_BITS-1:0] time_t;

  // Transaction opcodes.
  typedef enum logic [1:0] {
    OP_OBSERVE    = 2'd0,
    OP_QUARANTINE = 2'd1,
    OP_FORGET     = 2'd2
  } opcode_e;

  typedef enum logic {
    KIND_NOTE = 1'b0,
    KIND_CC   = 1'b1
  } trig_kind_e;

  typedef enum logic [1:0] {
    BEH_PULSE = 2'd0,
    BEH_GATE  = 2'd1,
    BEH_OTHER = 2'd2
  } behavior_e;

  typedef enum logic [1:0] {
    EDGE_RISING  = 2'd0,
    EDGE_FALLING = 2'd1,
    EDGE_BOTH    = 2'd2
  } edge_sel_e;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    REG_TRIGGER_KIND   = 3'd0,
    REG_BEHAVIOR_MODE  = 3'd1,
    REG_EDGE_SELECT    = 3'd2,
    REG_MIN_VELOCITY   = 3'd3,
    REG_HIGH_THRESHOLD = 3'd4,
    REG_LOW_THRESHOLD  = 3'd5,
    REG_DEBOUNCE_MS    = 3'd6
  } reg_idx_e;

  // States of the top-level sequencer.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SWEEP,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic        trigger_kind;
    logic [1:0]  behavior_mode;
    logic [1:0]  edge_select;
    logic [6:0]  min_velocity;
    logic [6:0]  high_threshold;
    logic [6:0]  low_threshold;
    logic [15:0] debounce_ms;
  } cfg_t;

  // One table entry. last_value[7] and region[1] are their valid flags.
  typedef struct packed {
    logic       held_down;
    logic       armed;
    logic       blocked;
    logic       is_pulse;
    logic [7:0] last_value;
    logic [1:0] region;
    time_t      last_change_time;
    time_t      last_fire_time;
    logic       has_fired;
  } entry_t;

  typedef struct packed {
    logic changed;
    logic activated;
    logic held;
    logic released;
    logic ready;
  } result_t;

  // Elapsed time modulo 2^TIME_BITS compared against a 16-bit limit.
  function automatic logic elapsed_ge(time_t now, time_t then, logic [15:0] limit);
    time_t diff;
    diff = now - then;
    return diff >= TIME_BITS'(limit);
  endfunction

  // Entry after a quarantine: pulse or held entries become blocked.
  function automatic entry_t quarantine_entry(entry_t e, time_t now);
    entry_t q;
    q = e;
    q.blocked = e.is_pulse | e.held_down;
    q.last_change_time = now;
    return q;
  endfunction

  function automatic logic slot_in_range(logic [1:0] slot);
    return {30'd0, slot} < 32'(SOURCE_SLOTS);
  endfunction

endpackage

>>> hdl/mtq_entry_ram.sv
// Simple dual-port synchronous RAM holding the per-entry trigger state.
// One write and one registered read per cycle; depends on nothing.
module mtq_entry_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hdl/mtq_cfg_regs.sv
// APB-style configuration registers of the trigger qualifier.
// Depends on mtq_pkg for the register indexes and the cfg_t bundle.
module mtq_cfg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mtq_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output mtq_pkg::cfg_t             cfg_o
);

  mtq_pkg::cfg_t     cfg_q, cfg_d;
  mtq_pkg::reg_idx_e idx;
  logic              wr_en;

  assign idx = mtq_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        mtq_pkg::REG_TRIGGER_KIND:   cfg_d.trigger_kind = pwdata[0];
        mtq_pkg::REG_BEHAVIOR_MODE:  cfg_d.behavior_mode = pwdata[1:0];
        mtq_pkg::REG_EDGE_SELECT:    cfg_d.edge_select = pwdata[1:0];
        mtq_pkg::REG_MIN_VELOCITY:   cfg_d.min_velocity = pwdata[6:0];
        mtq_pkg::REG_HIGH_THRESHOLD: cfg_d.high_threshold = pwdata[6:0];
        mtq_pkg::REG_LOW_THRESHOLD:  cfg_d.low_threshold = pwdata[6:0];
        mtq_pkg::REG_DEBOUNCE_MS:    cfg_d.debounce_ms = pwdata[15:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_kind   <= mtq_pkg::KIND_NOTE;
      cfg_q.behavior_mode  <= mtq_pkg::BEH_PULSE;
      cfg_q.edge_select    <= mtq_pkg::EDGE_RISING;
      cfg_q.min_velocity   <= 7'd1;
      cfg_q.high_threshold <= 7'd96;
      cfg_q.low_threshold  <= 7'd32;
      cfg_q.debounce_ms    <= 16'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Register read mux.
  always_comb begin
    unique case (idx)
      mtq_pkg::REG_TRIGGER_KIND:   prdata = 32'(cfg_q.trigger_kind);
      mtq_pkg::REG_BEHAVIOR_MODE:  prdata = 32'(cfg_q.behavior_mode);
      mtq_pkg::REG_EDGE_SELECT:    prdata = 32'(cfg_q.edge_select);
      mtq_pkg::REG_MIN_VELOCITY:   prdata = 32'(cfg_q.min_velocity);
      mtq_pkg::REG_HIGH_THRESHOLD: prdata = 32'(cfg_q.high_threshold);
      mtq_pkg::REG_LOW_THRESHOLD:  prdata = 32'(cfg_q.low_threshold);
      mtq_pkg::REG_DEBOUNCE_MS:    prdata = 32'(cfg_q.debounce_ms);
      default:                     prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> hdl/mtq_eval.sv
// Update of one table entry for an observed note or controller event.
// Depends on mtq_pkg for the entry, result and configuration types.
module mtq_eval (
  input  mtq_pkg::cfg_t   cfg_i,
  input  mtq_pkg::entry_t entry_i,
  input  logic [6:0]      val_i,
  input  logic            note_on_i,
  input  mtq_pkg::time_t  now_i,
  input  logic            allow_i,
  output mtq_pkg::entry_t entry_o,
  output mtq_pkg::result_t result_o
);

  mtq_pkg::entry_t ent;
  logic prev, down, raw_ok, reg_ok, next_hi, next_ok, hold;
  logic gate, changed, candidate, rdy, deb_ok, act;

  always_comb begin
    ent = entry_i;
    down = 1'b0;
    raw_ok = 1'b0;
    reg_ok = 1'b0;
    next_hi = 1'b0;
    next_ok = 1'b0;
    hold = 1'b0;
    changed = 1'b0;
    candidate = 1'b0;
    gate = cfg_i.behavior_mode == mtq_pkg::BEH_GATE;
    prev = entry_i.held_down;
    ent.is_pulse = (cfg_i.trigger_kind == mtq_pkg::KIND_CC) &&
                   (cfg_i.behavior_mode == mtq_pkg::BEH_PULSE);

    if (cfg_i.trigger_kind == mtq_pkg::KIND_NOTE) begin
      // Notes: a note-off (or zero velocity) re-arms and unblocks the entry.
      down = note_on_i && (val_i != 7'd0);
      changed = down != prev;
      if (!down) begin
        ent.armed = 1'b1;
        ent.blocked = 1'b0;
      end
      candidate = down && !prev && entry_i.armed && (val_i >= cfg_i.min_velocity);
      ent.held_down = down;
      ent.last_value = {1'b1, val_i};
    end else begin
      // Controllers: a blocked pulse entry clears after the settle time.
      raw_ok = entry_i.last_value[7];
      reg_ok = entry_i.region[1];
      changed = !raw_ok || (entry_i.last_value[6:0] != val_i);
      if (entry_i.blocked && ent.is_pulse &&
          mtq_pkg::elapsed_ge(now_i, entry_i.last_change_time, mtq_pkg::SETTLE_MS)) begin
        ent.blocked = 1'b0;
      end
      if (changed) begin
        ent.last_change_time = now_i;
        // Hysteresis; the high test wins when the thresholds cross.
        priority if (val_i >= cfg_i.high_threshold) begin
          next_hi = 1'b1;
          next_ok = 1'b1;
        end else if (val_i <= cfg_i.low_threshold) begin
          next_hi = 1'b0;
          next_ok = 1'b1;
        end else begin
          next_hi = entry_i.region[0];
          next_ok = reg_ok;
        end
        if (raw_ok && reg_ok && (next_hi != entry_i.region[0])) begin
          candidate = (cfg_i.edge_select == mtq_pkg::EDGE_BOTH) ||
                      (next_hi && (cfg_i.edge_select == mtq_pkg::EDGE_RISING)) ||
                      (!next_hi && (cfg_i.edge_select == mtq_pkg::EDGE_FALLING));
        end
        ent.region = next_ok ? {1'b1, next_hi} : 2'b00;
        ent.last_value = {1'b1, val_i};
        ent.armed = next_ok;
        hold = gate && next_ok &&
               ((cfg_i.edge_select == mtq_pkg::EDGE_RISING) ? next_hi : !next_hi);
        ent.held_down = hold;
        if (!hold && gate) begin
          ent.blocked = 1'b0;
        end
      end
    end

    // Firing needs permission, a ready entry and the debounce interval.
    rdy = ent.armed && !ent.blocked;
    deb_ok = !entry_i.has_fired ||
             mtq_pkg::elapsed_ge(now_i, entry_i.last_fire_time, cfg_i.debounce_ms);
    act = candidate && allow_i && rdy && deb_ok;
    if (act) begin
      ent.last_fire_time = now_i;
      ent.has_fired = 1'b1;
    end
  end

  assign entry_o = ent;
  assign result_o = '{changed:   changed,
                      activated: act,
                      held:      ent.held_down,
                      released:  prev && !ent.held_down,
                      ready:     rdy};

endmodule

>>> hdl/midi_trigger_qualifier_unit.sv
// Top level of the MIDI trigger qualifier: sequencer, entry RAM and valid bits.
// Depends on mtq_pkg, mtq_cfg_regs, mtq_entry_ram, mtq_eval and assert_macros.svh.
// Observe: the entry is read at acceptance and written back in the lookup state (RAM
// read-modify-write of one entry). Forget, unused opcodes: no RAM access. Quarantine walks
// all ENTRIES entries, then flushes. Only idle takes a transaction; a stalled result holds
// the block. Reset clears the per-entry valid bits at once, so no clearing pass is needed.
`include "assert_macros.svh"

module midi_trigger_qualifier_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Input channel.
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 opcode_i,
  input  logic [1:0]                 source_slot_i,
  input  logic [3:0]                 midi_channel_i,
  input  logic [6:0]                 data_value_i,
  input  logic                       note_is_on_i,
  input  logic [31:0]                time_ms_i,
  input  logic                       allow_fire_i,
  // Result channel.
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       changed_o,
  output logic                       activated_o,
  output logic                       held_o,
  output logic                       released_o,
  output logic                       ready_res_o,
  // Configuration port.
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mtq_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int AW = mtq_pkg::ENTRY_AW;
  localparam logic [AW:0] ENTRY_CNT = (AW + 1)'(mtq_pkg::ENTRIES);

  mtq_pkg::state_e  state_q, state_d;

  mtq_pkg::cfg_t    cfg;
  mtq_pkg::opcode_e op_in;
  logic             accept, slot_ok, out_free;

  // Captured transaction fields.
  logic [AW-1:0]    item_addr_q;
  logic [6:0]       item_val_q;
  logic             item_non_q, item_allow_q;
  mtq_pkg::time_t   item_now_q;

  // Quarantine walk.
  logic [AW:0]      swp_cnt_q, swp_cnt_d;
  logic             swp_wr_q, swp_wr_d;
  logic [AW-1:0]    swp_addr_q, swp_addr_d;

  // RAM interface and per-entry valid bits.
  logic             ram_re, ram_we;
  logic [AW-1:0]    ram_raddr, ram_waddr;
  logic [$bits(mtq_pkg::entry_t)-1:0] ram_rdata;
  mtq_pkg::entry_t  ram_wdata, ent_cur, ent_new;
  logic [mtq_pkg::ENTRIES-1:0] vld_q, vld_d;
  logic             ent_vld_q, forget_clr;

  // Result register.
  mtq_pkg::result_t res_new, res_q;
  logic             out_valid_q, load_res;

  mtq_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mtq_entry_ram #(
    .WIDTH ($bits(mtq_pkg::entry_t)),
    .DEPTH (mtq_pkg::ENTRIES)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (ram_re),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata)
  );

  // Entries never written since reset or a forget read as all zeros.
  assign ent_cur = ent_vld_q ? mtq_pkg::entry_t'(ram_rdata) : '0;

  mtq_eval u_eval (
    .cfg_i     (cfg),
    .entry_i   (ent_cur),
    .val_i     (item_val_q),
    .note_on_i (item_non_q),
    .now_i     (item_now_q),
    .allow_i   (item_allow_q),
    .entry_o   (ent_new),
    .result_o  (res_new)
  );

  assign op_in = mtq_pkg::opcode_e'(opcode_i);
  assign slot_ok = mtq_pkg::slot_in_range(source_slot_i);
  assign accept = in_valid_i && (state_q == mtq_pkg::ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // Next-state logic. Only the idle state takes a transaction, so the
  // read and the write-back of one entry never overlap another item.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mtq_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (op_in)
            mtq_pkg::OP_OBSERVE: begin
              state_d = slot_ok ? mtq_pkg::ST_LOOKUP : mtq_pkg::ST_FLUSH;
            end
            mtq_pkg::OP_QUARANTINE: state_d = mtq_pkg::ST_SWEEP;
            mtq_pkg::OP_FORGET:     state_d = mtq_pkg::ST_FLUSH;
            default:                state_d = mtq_pkg::ST_FLUSH;
          endcase
        end
      end
      mtq_pkg::ST_LOOKUP: begin
        if (out_free) state_d = mtq_pkg::ST_IDLE;
      end
      mtq_pkg::ST_SWEEP: begin
        if (swp_cnt_q == ENTRY_CNT) state_d = mtq_pkg::ST_FLUSH;
      end
      mtq_pkg::ST_FLUSH: begin
        if (out_free) state_d = mtq_pkg::ST_IDLE;
      end
      default: state_d = mtq_pkg::ST_IDLE;
    endcase
  end

  // Output logic of the sequencer.
  always_comb begin
    in_stall_o = 1'b1;
    ram_re = 1'b0;
    ram_raddr = swp_cnt_q[AW-1:0];
    ram_we = 1'b0;
    ram_waddr = swp_addr_q;
    ram_wdata = mtq_pkg::quarantine_entry(ent_cur, item_now_q);
    load_res = 1'b0;
    forget_clr = 1'b0;
    unique case (state_q)
      mtq_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        ram_raddr = AW'({source_slot_i, midi_channel_i});
        ram_re = accept && (op_in == mtq_pkg::OP_OBSERVE) && slot_ok;
        forget_clr = accept && (op_in == mtq_pkg::OP_FORGET) && slot_ok;
      end
      mtq_pkg::ST_LOOKUP: begin
        ram_we = out_free;
        ram_waddr = item_addr_q;
        ram_wdata = ent_new;
        load_res = out_free;
      end
      mtq_pkg::ST_SWEEP: begin
        ram_re = swp_cnt_q < ENTRY_CNT;
        ram_we = swp_wr_q;
      end
      mtq_pkg::ST_FLUSH: begin
        load_res = out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mtq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture the transaction fields at acceptance.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_addr_q  <= AW'({source_slot_i, midi_channel_i});
      item_val_q   <= data_value_i;
      item_non_q   <= note_is_on_i;
      item_now_q   <= mtq_pkg::TIME_BITS'(time_ms_i);
      item_allow_q <= allow_fire_i;
    end
  end

  // Quarantine walk: read entry n while entry n-1 is written back.
  always_comb begin
    swp_cnt_d = swp_cnt_q;
    swp_wr_d = swp_wr_q;
    swp_addr_d = swp_addr_q;
    if (accept) begin
      swp_cnt_d = '0;
      swp_wr_d = 1'b0;
    end else if (state_q == mtq_pkg::ST_SWEEP) begin
      swp_wr_d = swp_cnt_q < ENTRY_CNT;
      swp_addr_d = swp_cnt_q[AW-1:0];
      if (swp_cnt_q < ENTRY_CNT) swp_cnt_d = swp_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swp_cnt_q <= '0;
      swp_wr_q  <= 1'b0;
    end else begin
      swp_cnt_q <= swp_cnt_d;
      swp_wr_q  <= swp_wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    swp_addr_q <= swp_addr_d;
  end

  // Valid bits: set on every write-back, cleared per source by forget.
  always_comb begin
    vld_d = vld_q;
    if (forget_clr) begin
      for (int i = 0; i < mtq_pkg::ENTRIES; i++) begin
        if ((i / mtq_pkg::CHANNELS) == int'(source_slot_i)) vld_d[i] = 1'b0;
      end
    end
    if (ram_we) vld_d[ram_waddr] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // The valid flag travels with the registered RAM read data.
  always_ff @(posedge clk_i) begin
    if (ram_re) ent_vld_q <= vld_q[ram_raddr];
  end

  // Result register; it holds while the receiver stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_res) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      res_q <= (state_q == mtq_pkg::ST_LOOKUP) ? res_new : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign changed_o   = res_q.changed;
  assign activated_o = res_q.activated;
  assign held_o      = res_q.held;
  assign released_o  = res_q.released;
  assign ready_res_o = res_q.ready;

  // Checks on the sequencer and the RAM traffic.
  `MTQ_ASSERT_NEVER(a_rw_same_entry, clk_i, rst_ni, ram_we && ram_re && (ram_waddr == ram_raddr), "read and write of one entry in one cycle")
  `MTQ_ASSERT(a_sweep_bound, clk_i, rst_ni, (state_q == mtq_pkg::ST_SWEEP) |-> (swp_cnt_q <= ENTRY_CNT), "quarantine walk ran past the table")
  `MTQ_ASSERT(a_lookup_read, clk_i, rst_ni, ((state_q == mtq_pkg::ST_LOOKUP) && !$past(state_q == mtq_pkg::ST_LOOKUP)) |-> $past(ram_re), "lookup entered without a RAM read")
  `MTQ_ASSERT(a_fire_ready, clk_i, rst_ni, (out_valid_q && res_q.activated) |-> res_q.ready, "activation reported on an entry that is not ready")

endmodule
